// ----- design/rrfp_pkg.sv -----
// Shared constants and types for the radio receive frame parser.
package rrfp_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;

    localparam int unsigned MODE_W  = 4;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDRESS = 1'd1;

    localparam logic [ADDR_W-1:0] PEER_ADDRESS_RESET = 24'h393939;

    localparam logic [MODE_W-1:0] M_IDLE     = 4'd0;
    localparam logic [MODE_W-1:0] M_HUNT     = 4'd1;
    localparam logic [MODE_W-1:0] M_HDR_R    = 4'd2;
    localparam logic [MODE_W-1:0] M_HDR_T    = 4'd3;
    localparam logic [MODE_W-1:0] M_ADDR_R   = 4'd4;
    localparam logic [MODE_W-1:0] M_ADDR_T   = 4'd5;
    localparam logic [MODE_W-1:0] M_RPT1_ONE = 4'd6;
    localparam logic [MODE_W-1:0] M_RPT1_TWO = 4'd7;
    localparam logic [MODE_W-1:0] M_RPT2     = 4'd8;
    localparam logic [MODE_W-1:0] M_LEN      = 4'd9;
    localparam logic [MODE_W-1:0] M_PAYLOAD  = 4'd10;
    localparam logic [MODE_W-1:0] M_FOOTER   = 4'd11;
    localparam logic [MODE_W-1:0] M_RSSI     = 4'd12;

    localparam logic [7:0]  CHAR_R    = 8'h52;
    localparam logic [7:0]  CHAR_T    = 8'h54;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [15:0] HDR_BN    = 16'h424E;
    localparam logic [15:0] HDR_BR    = 16'h4252;
    localparam logic [15:0] HDR_B2    = 16'h4232;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ONE  = 2'd1;
    localparam logic [1:0] ACK_TWO  = 2'd2;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       rssi_valid;
        logic [7:0] rssi_value;
        logic [1:0] ack_busy;
    } t_result;

endpackage

// ----- design/radio_rx_frame_parser.sv -----
// Radio receive frame parser: deframes modem reply frames one byte per transfer.
//
// Bytes from the modem link enter on the s_axis channel, one byte per transfer.
// Every accepted byte yields exactly one result transfer on the m_axis channel,
// carrying a payload byte with its last mark, a decoded signal strength, or an
// acknowledge-busy event; a byte that produces none of these still yields a
// result with all flags clear.
// The parser state is updated in the cycle the byte is accepted and the result
// is held in the output register, or in the skid register while the output register is full.
// One byte is accepted in every cycle while s_axis_tready is high; the rate is
// set by the single parse step between the input handshake and the output register.
// A skid register sits behind the output register, so a byte is still taken
// while one result waits; s_axis_tready falls only when both are occupied and
// rises again as soon as the receiver takes a transfer.
// Reset leaves the receiver disabled, the parser idle, both result registers empty and
// the expected peer address at "999". The user must write configuration through i_cfg_we,
// i_cfg_addr and i_cfg_wdata only while no frame is in flight; the block does not check.
module radio_rx_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrfp_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [rrfp_pkg::ADDR_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // data_byte, rssi_value
    output logic                          m_axis_tlast,   // data_last
    output logic [3:0]                    m_axis_tuser    // data_valid, rssi_valid, ack_busy
);

    logic                            r_rx_enable;
    logic [rrfp_pkg::ADDR_W-1:0]     r_peer_address;

    logic [rrfp_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [1:0]                      r_field_count, n_field_count;
    logic [rrfp_pkg::ADDR_W-1:0]     r_match_shift, n_match_shift;
    logic [rrfp_pkg::LEN_W-1:0]      r_length_left, n_length_left;
    logic [7:0]                      r_rssi_accum, n_rssi_accum;

    rrfp_pkg::t_result               n_result;
    rrfp_pkg::t_result               r_out, r_skid;
    logic                            r_out_valid, r_skid_valid;

    logic                            accept;
    logic                            out_load;
    logic [7:0]                      digit;
    logic [1:0]                      count_inc;
    logic [rrfp_pkg::ADDR_W-1:0]     shifted;
    logic [rrfp_pkg::LEN_W-1:0]      len_dec;
    logic [rrfp_pkg::LEN_W-1:0]      len_acc;
    logic [7:0]                      rssi_acc;
    logic [rrfp_pkg::MODE_W-1:0]     mode_eff;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = !r_out_valid || m_axis_tready;

    assign digit     = s_axis_tdata - rrfp_pkg::CHAR_ZERO;
    assign count_inc = r_field_count + 2'd1;
    assign shifted   = {r_match_shift[rrfp_pkg::ADDR_W-9:0], s_axis_tdata};
    assign len_dec   = r_length_left - 16'd1;
    assign len_acc   = (r_length_left << 3) + (r_length_left << 1)
                       + ({8'd0, s_axis_tdata} - {8'd0, rrfp_pkg::CHAR_ZERO});
    assign rssi_acc  = (r_rssi_accum << 3) + (r_rssi_accum << 1) + digit;
    assign mode_eff  = (r_mode == rrfp_pkg::M_IDLE) ? rrfp_pkg::M_HUNT : r_mode;

    always_comb begin
        n_mode        = r_mode;
        n_field_count = r_field_count;
        n_match_shift = r_match_shift;
        n_length_left = r_length_left;
        n_rssi_accum  = r_rssi_accum;
        n_result      = '0;
        if (!r_rx_enable) begin
            n_mode = rrfp_pkg::M_IDLE;
        end else begin
            n_mode = mode_eff;
            case (mode_eff)
                rrfp_pkg::M_PAYLOAD: begin
                    n_result.data_valid = 1'b1;
                    n_result.data_byte  = s_axis_tdata;
                    n_length_left       = len_dec;
                    if (len_dec == '0) begin
                        n_result.data_last = 1'b1;
                        n_mode             = rrfp_pkg::M_FOOTER;
                    end
                end
                rrfp_pkg::M_HDR_R, rrfp_pkg::M_HDR_T: begin
                    n_match_shift = shifted;
                    n_field_count = count_inc;
                    if (count_inc == 2'd2) begin
                        n_field_count = 2'd0;
                        n_match_shift = '0;
                        if (shifted[15:0] == rrfp_pkg::HDR_BN) begin
                            n_mode = (mode_eff == rrfp_pkg::M_HDR_R) ?
                                     rrfp_pkg::M_ADDR_R : rrfp_pkg::M_ADDR_T;
                        end else if (shifted[15:0] == rrfp_pkg::HDR_BR) begin
                            n_mode            = rrfp_pkg::M_RPT1_ONE;
                            n_result.ack_busy = rrfp_pkg::ACK_ONE;
                        end else if (shifted[15:0] == rrfp_pkg::HDR_B2) begin
                            n_mode            = rrfp_pkg::M_RPT1_TWO;
                            n_result.ack_busy = rrfp_pkg::ACK_TWO;
                        end else begin
                            n_mode = rrfp_pkg::M_HUNT;
                        end
                    end
                end
                rrfp_pkg::M_RPT1_ONE, rrfp_pkg::M_RPT1_TWO, rrfp_pkg::M_RPT2: begin
                    n_field_count = count_inc;
                    if (count_inc == 2'd3) begin
                        n_mode = (mode_eff == rrfp_pkg::M_RPT1_TWO) ?
                                 rrfp_pkg::M_RPT2 : rrfp_pkg::M_ADDR_R;
                        n_field_count = 2'd0;
                    end
                end
                rrfp_pkg::M_ADDR_R, rrfp_pkg::M_ADDR_T: begin
                    n_match_shift = shifted;
                    n_field_count = count_inc;
                    if (count_inc == 2'd3) begin
                        if (mode_eff == rrfp_pkg::M_ADDR_T || shifted == r_peer_address) begin
                            n_mode        = rrfp_pkg::M_LEN;
                            n_field_count = 2'd0;
                            n_length_left = '0;
                        end else begin
                            n_mode = rrfp_pkg::M_HUNT;
                        end
                    end
                end
                rrfp_pkg::M_LEN: begin
                    n_length_left = len_acc;
                    n_field_count = count_inc;
                    if (count_inc == 2'd3) begin
                        n_field_count = 2'd0;
                        if (len_acc != '0 && len_acc <= rrfp_pkg::LEN_W'(rrfp_pkg::MAX_PAYLOAD))
                        begin
                            n_mode = rrfp_pkg::M_PAYLOAD;
                        end else begin
                            n_mode = rrfp_pkg::M_HUNT;
                        end
                    end
                end
                rrfp_pkg::M_FOOTER: begin
                    if (digit <= 8'd1) begin
                        n_rssi_accum  = digit;
                        n_field_count = 2'd1;
                        n_mode        = rrfp_pkg::M_RSSI;
                    end else begin
                        n_mode = rrfp_pkg::M_HUNT;
                    end
                end
                rrfp_pkg::M_RSSI: begin
                    if (digit <= 8'd9) begin
                        n_rssi_accum  = rssi_acc;
                        n_field_count = count_inc;
                        if (count_inc == 2'd3) begin
                            n_result.rssi_valid = 1'b1;
                            n_result.rssi_value = rssi_acc;
                            n_mode              = rrfp_pkg::M_HUNT;
                        end
                    end else begin
                        n_mode = rrfp_pkg::M_HUNT;
                    end
                end
                default: begin
                    if (s_axis_tdata == rrfp_pkg::CHAR_R) begin
                        n_mode        = rrfp_pkg::M_HDR_R;
                        n_field_count = 2'd0;
                        n_match_shift = '0;
                    end else if (s_axis_tdata == rrfp_pkg::CHAR_T) begin
                        n_mode        = rrfp_pkg::M_HDR_T;
                        n_field_count = 2'd0;
                        n_match_shift = '0;
                    end else begin
                        n_mode = rrfp_pkg::M_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable    <= 1'b0;
            r_peer_address <= rrfp_pkg::PEER_ADDRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rrfp_pkg::CFG_RX_ENABLE:    r_rx_enable    <= i_cfg_wdata[0];
                rrfp_pkg::CFG_PEER_ADDRESS: r_peer_address <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rrfp_pkg::M_IDLE;
            r_field_count <= '0;
            r_match_shift <= '0;
            r_length_left <= '0;
            r_rssi_accum  <= '0;
        end else if (accept) begin
            r_mode        <= n_mode;
            r_field_count <= n_field_count;
            r_match_shift <= n_match_shift;
            r_length_left <= n_length_left;
            r_rssi_accum  <= n_rssi_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_load) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (accept && !out_load) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.rssi_value, r_out.data_byte};
    assign m_axis_tlast  = r_out.data_last;
    assign m_axis_tuser  = {r_out.ack_busy, r_out.rssi_valid, r_out.data_valid};

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the radio receive frame parser with a byte-level predictor.
`timescale 1ns / 1ps

module tb_top;
    import rrfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_AT     = 400;
    localparam int unsigned HOLD_LEN    = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [ADDR_W-1:0]    i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic [3:0]           m_axis_tuser;

    radio_rx_frame_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // data_byte, rssi_value
        .m_axis_tlast  (m_axis_tlast),   // data_last
        .m_axis_tuser  (m_axis_tuser)    // data_valid, rssi_valid, ack_busy
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state and its copy of the configuration.
    logic              rx_on     = 1'b0;
    logic [ADDR_W-1:0] peer_addr = PEER_ADDRESS_RESET;
    logic [MODE_W-1:0] rx_mode   = M_IDLE;
    logic [1:0]        digit_cnt = '0;
    logic [23:0]       match_reg = '0;
    logic [LEN_W-1:0]  len_rem   = '0;
    logic [7:0]        rssi_sum  = '0;

    logic [7:0]  tx_bytes[$];
    t_result     due_results[$];
    t_result     mon_got;
    t_result     mon_want;

    int unsigned cycle_cnt   = 0;
    int unsigned bytes_in    = 0;
    int unsigned stim_bytes  = 0;
    int unsigned send_gap    = 0;
    int unsigned ready_gap   = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    int unsigned errors      = 0;
    int unsigned n_results   = 0;
    int unsigned n_payload   = 0;
    int unsigned n_frames    = 0;
    int unsigned n_rssi      = 0;
    int unsigned n_ack       = 0;

    function automatic t_result parse_rx_byte(input logic [7:0] c);
        t_result     r;
        logic [7:0]  dig;
        logic [15:0] hdr;
        r   = '0;
        dig = c - CHAR_ZERO;
        if (!rx_on) begin
            rx_mode = M_IDLE;
            return r;
        end
        if (rx_mode == M_IDLE)
            rx_mode = M_HUNT;
        case (rx_mode)
            M_PAYLOAD: begin
                r.data_valid = 1'b1;
                r.data_byte  = c;
                len_rem      = len_rem - 1'b1;
                if (len_rem == 0) begin
                    r.data_last = 1'b1;
                    rx_mode     = M_FOOTER;
                end
            end
            M_HDR_R, M_HDR_T: begin
                match_reg = {match_reg[15:0], c};
                digit_cnt = digit_cnt + 1'b1;
                if (digit_cnt == 2'd2) begin
                    hdr       = match_reg[15:0];
                    digit_cnt = '0;
                    match_reg = '0;
                    if (hdr == HDR_BN) begin
                        rx_mode = (rx_mode == M_HDR_R) ? M_ADDR_R : M_ADDR_T;
                    end else if (hdr == HDR_BR) begin
                        rx_mode    = M_RPT1_ONE;
                        r.ack_busy = ACK_ONE;
                    end else if (hdr == HDR_B2) begin
                        rx_mode    = M_RPT1_TWO;
                        r.ack_busy = ACK_TWO;
                    end else begin
                        rx_mode = M_HUNT;
                    end
                end
            end
            M_RPT1_ONE, M_RPT1_TWO, M_RPT2: begin
                digit_cnt = digit_cnt + 1'b1;
                if (digit_cnt == 2'd3) begin
                    rx_mode   = (rx_mode == M_RPT1_TWO) ? M_RPT2 : M_ADDR_R;
                    digit_cnt = '0;
                end
            end
            M_ADDR_R, M_ADDR_T: begin
                match_reg = {match_reg[15:0], c};
                digit_cnt = digit_cnt + 1'b1;
                if (digit_cnt == 2'd3) begin
                    if (rx_mode == M_ADDR_T || match_reg == peer_addr) begin
                        rx_mode   = M_LEN;
                        digit_cnt = '0;
                        len_rem   = '0;
                    end else begin
                        rx_mode = M_HUNT;
                    end
                end
            end
            M_LEN: begin
                len_rem   = len_rem * 16'd10 + ({8'h00, c} - {8'h00, CHAR_ZERO});
                digit_cnt = digit_cnt + 1'b1;
                if (digit_cnt == 2'd3) begin
                    digit_cnt = '0;
                    if (len_rem != 0 && len_rem <= MAX_PAYLOAD)
                        rx_mode = M_PAYLOAD;
                    else
                        rx_mode = M_HUNT;
                end
            end
            M_FOOTER: begin
                if (dig <= 8'd1) begin
                    rssi_sum  = dig;
                    digit_cnt = 2'd1;
                    rx_mode   = M_RSSI;
                end else begin
                    rx_mode = M_HUNT;
                end
            end
            M_RSSI: begin
                if (dig <= 8'd9) begin
                    rssi_sum  = rssi_sum * 8'd10 + dig;
                    digit_cnt = digit_cnt + 1'b1;
                    if (digit_cnt == 2'd3) begin
                        r.rssi_valid = 1'b1;
                        r.rssi_value = rssi_sum;
                        rx_mode      = M_HUNT;
                    end
                end else begin
                    rx_mode = M_HUNT;
                end
            end
            default: begin
                if (c == CHAR_R) begin
                    rx_mode   = M_HDR_R;
                    digit_cnt = '0;
                    match_reg = '0;
                end else if (c == CHAR_T) begin
                    rx_mode   = M_HDR_T;
                    digit_cnt = '0;
                    match_reg = '0;
                end else begin
                    rx_mode = M_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    // Most gaps are short; one stretch in four, picked by bits 8:7 of the cycle counter, has none at all.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_cnt[8:7] == 2'b00 || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        stim_bytes++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_random(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_byte(8'($urandom));
    endtask

    task automatic push_number(input int unsigned n);
        push_byte(8'(CHAR_ZERO + n / 100));
        push_byte(8'(CHAR_ZERO + (n / 10) % 10));
        push_byte(8'(CHAR_ZERO + n % 10));
    endtask

    task automatic push_random_frame();
        int unsigned r;
        int unsigned n_rpt;
        int unsigned len;
        int unsigned pay_n;
        logic [15:0] hdr;
        logic [23:0] src;
        logic [7:0]  b;
        push_byte(($urandom_range(0, 1) == 0) ? CHAR_R : CHAR_T);
        r   = $urandom_range(0, 99);
        hdr = (r < 30) ? HDR_BN : (r < 58) ? HDR_BR : (r < 86) ? HDR_B2 : 16'($urandom);
        push_byte(hdr[15:8]);
        push_byte(hdr[7:0]);
        n_rpt = (hdr == HDR_BR) ? 1 : (hdr == HDR_B2) ? 2 : 0;
        push_random(3 * n_rpt);
        src = ($urandom_range(0, 99) < 85) ? peer_addr : 24'($urandom);
        push_byte(src[23:16]);
        push_byte(src[15:8]);
        push_byte(src[7:0]);
        r = $urandom_range(0, 99);
        if (r < 80)
            len = $urandom_range(1, 6);
        else if (r < 88)
            len = $urandom_range(7, MAX_PAYLOAD);
        else if (r < 91)
            len = ($urandom_range(0, 1) == 0) ? 1 : MAX_PAYLOAD;
        else if (r < 94)
            len = 0;
        else
            len = $urandom_range(MAX_PAYLOAD + 1, 999);
        if ($urandom_range(0, 99) < 4) begin
            push_random(3);
            len = 0;
        end else begin
            push_number(len);
        end
        if (len >= 1 && len <= MAX_PAYLOAD)
            pay_n = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len - 1) : len;
        else
            pay_n = $urandom_range(0, 3);
        push_random(pay_n);
        r = $urandom_range(0, 99);
        if (r < 65) begin
            push_byte(8'(CHAR_ZERO + $urandom_range(0, 1)));
            push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end else if (r < 80) begin
            push_byte(8'h0D);
        end else if (r < 90) begin
            do
                b = 8'($urandom);
            while (b == CHAR_ZERO || b == CHAR_ZERO + 8'd1);
            push_byte(b);
        end else begin
            push_byte(8'(CHAR_ZERO + $urandom_range(0, 1)));
            push_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h2F))
                                                  : 8'($urandom_range(8'h3A, 8'hFF)));
        end
        if ($urandom_range(0, 99) < 20)
            push_random($urandom_range(1, 4));
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        wait_idle();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_RX_ENABLE)
            rx_on = val[0];
        else
            peer_addr = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_cnt, due_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(parse_rx_byte(s_axis_tdata));
                bytes_in <= bytes_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tx_bytes.pop_front();
                    send_gap      <= draw_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // A single long hold-off on the result side, so that the input side backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_gap     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (ready_gap != 0) begin
            m_axis_tready <= 1'b0;
            ready_gap     <= ready_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            ready_gap     <= draw_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got.data_valid = m_axis_tuser[0];
            mon_got.rssi_valid = m_axis_tuser[1];
            mon_got.ack_busy   = m_axis_tuser[3:2];
            mon_got.data_byte  = m_axis_tdata[7:0];
            mon_got.rssi_value = m_axis_tdata[15:8];
            mon_got.data_last  = m_axis_tlast;
            n_results++;
            if (mon_got.data_valid === 1'b1)
                n_payload++;
            if (mon_got.data_last === 1'b1)
                n_frames++;
            if (mon_got.rssi_valid === 1'b1)
                n_rssi++;
            if (mon_got.ack_busy !== ACK_NONE)
                n_ack++;
            if (due_results.size() == 0) begin
                $error("Result transfer arrived with nothing expected.");
                errors++;
            end else begin
                mon_want = due_results.pop_front();
                check_field("data_valid", mon_want.data_valid, mon_got.data_valid);
                check_field("data_byte", mon_want.data_byte, mon_got.data_byte);
                check_field("data_last", mon_want.data_last, mon_got.data_last);
                check_field("rssi_valid", mon_want.rssi_valid, mon_got.rssi_valid);
                check_field("rssi_value", mon_want.rssi_value, mon_got.rssi_value);
                check_field("ack_busy", mon_want.ack_busy, mon_got.ack_busy);
            end
        end
    end

    initial begin
        int unsigned stop_at;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The receiver is still disabled, so this whole frame is dropped.
        push_text("RBN999002");
        push_random(2);
        push_text("123");

        write_reg(CFG_PEER_ADDRESS, 24'h343832);
        write_reg(CFG_RX_ENABLE, 24'd1);

        push_text("RBN482001");
        push_byte(8'h00);
        push_text("199");
        push_text("RBN482002");
        push_byte(8'hFF);
        push_byte(8'h80);
        push_text("000");
        push_text("TBN999003abc150");
        push_text("RBR111482001x042");
        push_text("RB2111222482001y7");
        push_text("TBR555482001z1x");
        push_text("TB2000111999001q");
        push_text("RBN123001q");
        push_text("RBXq");
        push_text("RBN482000");
        push_text("RBN482129");
        push_text("RBN48201:");
        push_random(20);
        push_text("088");
        // A frame with no footer: the next start byte is eaten as a bad footer.
        push_text("RBN482128");
        push_random(MAX_PAYLOAD);
        push_text("RBN482001");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("x");

        write_reg(CFG_PEER_ADDRESS, 24'h343832);
        stop_at = stim_bytes + 90;
        while (stim_bytes < stop_at)
            push_random_frame();

        write_reg(CFG_PEER_ADDRESS, 24'hFFFFFF);
        stop_at = stim_bytes + 50;
        while (stim_bytes < stop_at)
            push_random_frame();

        write_reg(CFG_PEER_ADDRESS, 24'h000000);
        stop_at = stim_bytes + 50;
        while (stim_bytes < stop_at)
            push_random_frame();

        write_reg(CFG_RX_ENABLE, 24'd0);
        push_random_frame();
        push_random_frame();

        write_reg(CFG_RX_ENABLE, 24'd1);
        write_reg(CFG_PEER_ADDRESS, 24'h393530);
        stop_at = stim_bytes + 40;
        while (stim_bytes < stop_at)
            push_random_frame();

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d results from %0d bytes: %0d payload bytes closing %0d frames,",
                 n_results, bytes_in, n_payload, n_frames);
        $display("%0d signal readings and %0d repeater acks over five address settings.",
                 n_rssi, n_ack);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
